>>> rtl/ihdk_pkg.sv
// Package with the item types, status codes and sequencer states of the indexed min-heap.
package ihdk_pkg;

    // Status codes reported with every result item.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DECREASED = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_POPPED    = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_BAD_VERT  = 3'd6
    } status_t;

    // Operation selected by the mode field.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Request item.
    typedef struct packed {
        logic        mode;
        logic [7:0]  vertex;
        logic [7:0]  source;
        logic [31:0] weight;
    } req_item_t;

    // Result item.
    typedef struct packed {
        status_t     status;
        logic [7:0]  out_vertex;
        logic [7:0]  out_source;
        logic [31:0] out_weight;
        logic [8:0]  count;
        logic        empty_res;
    } rsp_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_KEY,
        S_POP_ROOT,
        S_POP_LAST,
        S_UP,
        S_UP_CMP,
        S_DOWN,
        S_DOWN_L,
        S_DOWN_R,
        S_DONE
    } state_t;

endpackage

>>> rtl/ihdk_heap_ram.sv
// Heap entry memory: one write port and one registered read port.
module ihdk_heap_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ihdk_slot_map.sv
// Vertex to heap slot map: slot memory with a present bit per vertex held in flip-flops.
module ihdk_slot_map #(
    parameter int SLOT_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [7:0]        waddr,
    input  logic [SLOT_W-1:0] wdata,
    input  logic [7:0]        raddr,
    output logic [SLOT_W-1:0] rdata,
    input  logic              set_en,
    input  logic [7:0]        set_vertex,
    input  logic              clr_en,
    input  logic [7:0]        clr_vertex,
    input  logic [7:0]        test_vertex,
    output logic              present
);

    logic [SLOT_W-1:0] mem [256];
    logic [255:0]      valid_reg;

    // Slot memory with registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    // Present bits, all absent after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (set_en)
            begin
                valid_reg[set_vertex] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_vertex] <= 1'b0;
            end
        end
    end

    assign present = valid_reg[test_vertex];

endmodule

>>> rtl/indexed_min_heap_decrease_key.sv
// Top level of the indexed binary min-heap with decrease-key.
// One item is worked at a time and gives exactly one result item. A push that
// inserts or decreases a key sifts its entry up level by level, and a pop
// moves the last entry to the root and sifts it down. Each item then hands its
// result to the output register once that register is free. The sift steps are
// paced by the single read port of the heap memory: every compare of a sift
// step waits for its registered read data. Underflow, overflow and a bad vertex
// need no memory access, and an ignored push writes nothing. The present bits
// of the vertex map are flip-flops cleared by reset, so no clearing pass is
// needed. A new item is taken only while the sequencer is idle.
module indexed_min_heap_decrease_key #(
    parameter int CAPACITY    = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ihdk_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ihdk_pkg::rsp_item_t rsp
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;
    localparam int ENT_W  = 16 + WEIGHT_BITS;

    typedef struct packed {
        logic [7:0]             dst;
        logic [7:0]             src;
        logic [WEIGHT_BITS-1:0] w;
    } entry_t;

    ihdk_pkg::state_t    state_reg, state_next;
    ihdk_pkg::status_t   status_reg, status_next;
    ihdk_pkg::req_item_t in_reg, in_next;
    entry_t              ent_reg, ent_next;
    entry_t              res_reg, res_next;
    entry_t              cand_reg, cand_next;
    logic                sel_reg, sel_next;
    logic [SLOT_W-1:0]   k_reg, k_next;
    logic [SLOT_W-1:0]   p_reg, p_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    ihdk_pkg::rsp_item_t out_reg, out_next;

    // Memory interfaces.
    logic              heap_we;
    logic [SLOT_W-1:0] heap_waddr, heap_raddr;
    entry_t            heap_wdata, heap_rdata;
    logic [ENT_W-1:0]  heap_rbits;
    logic              slot_we;
    logic [7:0]        slot_waddr, slot_raddr;
    logic [SLOT_W-1:0] slot_wdata, slot_rdata;
    logic              set_en, clr_en, present;
    logic [7:0]        set_vertex, clr_vertex;

    // Derived values.
    logic [63:0]            w_wide;
    logic [WEIGHT_BITS-1:0] w_in, w_req;
    logic [IDX_W-1:0]       l_idx, r_idx, cnt_idx;
    logic [SLOT_W-1:0]      k_m1, parent;
    logic [16:0]            cnt_wide;
    logic [63:0]            ow_wide;

    function automatic logic [WEIGHT_BITS-1:0] ent_wt(input logic [31:0] x);
        logic [63:0] xw;
        xw = {32'b0, x};
        return xw[WEIGHT_BITS-1:0];
    endfunction

    ihdk_heap_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (ENT_W)
    ) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rbits)
    );

    assign heap_rdata = heap_rbits;

    ihdk_slot_map #(
        .SLOT_W (SLOT_W)
    ) u_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .we          (slot_we),
        .waddr       (slot_waddr),
        .wdata       (slot_wdata),
        .raddr       (slot_raddr),
        .rdata       (slot_rdata),
        .set_en      (set_en),
        .set_vertex  (set_vertex),
        .clr_en      (clr_en),
        .clr_vertex  (clr_vertex),
        .test_vertex (req.vertex),
        .present     (present)
    );

    // Weight of the incoming and the captured item, held in WEIGHT_BITS bits.
    assign w_wide  = {32'b0, req.weight};
    assign w_req   = w_wide[WEIGHT_BITS-1:0];
    assign w_in    = ent_wt(in_reg.weight);
    assign l_idx   = IDX_W'({k_reg, 1'b1});
    assign r_idx   = l_idx + 1'b1;
    assign cnt_idx = IDX_W'(count_reg);
    assign k_m1    = k_reg - 1'b1;
    assign parent  = SLOT_W'(k_m1 >> 1);

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ihdk_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        in_reg     <= in_next;
        ent_reg    <= ent_next;
        res_reg    <= res_next;
        cand_reg   <= cand_next;
        sel_reg    <= sel_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        out_reg    <= out_next;
    end

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        in_next        = in_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        cand_next      = cand_reg;
        sel_next       = sel_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        heap_we        = 1'b0;
        heap_waddr     = k_reg;
        heap_wdata     = ent_reg;
        heap_raddr     = '0;
        slot_we        = 1'b0;
        slot_waddr     = ent_reg.dst;
        slot_wdata     = k_reg;
        slot_raddr     = req.vertex;
        set_en         = 1'b0;
        set_vertex     = req.vertex;
        clr_en         = 1'b0;
        clr_vertex     = heap_rdata.dst;
        cnt_wide       = 17'(count_reg);
        ow_wide        = 64'(res_reg.w);
        req_ready      = (state_reg == ihdk_pkg::S_IDLE);

        unique case (state_reg)
            ihdk_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    in_next  = req;
                    res_next = '0;
                    if (req.mode == ihdk_pkg::MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ihdk_pkg::ST_UNDERFLOW;
                            state_next  = ihdk_pkg::S_DONE;
                        end
                        else
                        begin
                            heap_raddr = '0;
                            state_next = ihdk_pkg::S_POP_ROOT;
                        end
                    end
                    else if (17'(req.vertex) >= 17'(CAPACITY))
                    begin
                        status_next = ihdk_pkg::ST_BAD_VERT;
                        state_next  = ihdk_pkg::S_DONE;
                    end
                    else if (present)
                    begin
                        slot_raddr = req.vertex;
                        state_next = ihdk_pkg::S_SLOT;
                    end
                    else if (17'(count_reg) >= 17'(CAPACITY))
                    begin
                        status_next = ihdk_pkg::ST_OVERFLOW;
                        state_next  = ihdk_pkg::S_DONE;
                    end
                    else
                    begin
                        ent_next    = '{dst: req.vertex, src: req.source, w: w_req};
                        k_next      = SLOT_W'(count_reg);
                        count_next  = count_reg + 1'b1;
                        set_en      = 1'b1;
                        status_next = ihdk_pkg::ST_INSERTED;
                        state_next  = ihdk_pkg::S_UP;
                    end
                end
            end

            // Slot of a vertex already present: fetch its entry, or ignore the push if the slot lies beyond the count.
            ihdk_pkg::S_SLOT:
            begin
                if (CNT_W'(slot_rdata) < count_reg)
                begin
                    heap_raddr = slot_rdata;
                    k_next     = slot_rdata;
                    state_next = ihdk_pkg::S_KEY;
                end
                else
                begin
                    status_next = ihdk_pkg::ST_IGNORED;
                    state_next  = ihdk_pkg::S_DONE;
                end
            end

            // Decrease only on a strictly smaller weight.
            ihdk_pkg::S_KEY:
            begin
                if (w_in < heap_rdata.w)
                begin
                    ent_next    = '{dst: heap_rdata.dst, src: in_reg.source, w: w_in};
                    status_next = ihdk_pkg::ST_DECREASED;
                    state_next  = ihdk_pkg::S_UP;
                end
                else
                begin
                    status_next = ihdk_pkg::ST_IGNORED;
                    state_next  = ihdk_pkg::S_DONE;
                end
            end

            // Root leaves the heap; fetch the last entry unless the heap empties.
            ihdk_pkg::S_POP_ROOT:
            begin
                res_next    = heap_rdata;
                clr_en      = 1'b1;
                clr_vertex  = heap_rdata.dst;
                count_next  = count_reg - 1'b1;
                heap_raddr  = SLOT_W'(count_reg - 1'b1);
                status_next = ihdk_pkg::ST_POPPED;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ihdk_pkg::S_DONE;
                end
                else
                begin
                    state_next = ihdk_pkg::S_POP_LAST;
                end
            end

            ihdk_pkg::S_POP_LAST:
            begin
                ent_next   = heap_rdata;
                k_next     = '0;
                state_next = ihdk_pkg::S_DOWN;
            end

            // Sift up: read the parent of the hole, or write the entry at the root.
            ihdk_pkg::S_UP:
            begin
                if (k_reg == '0)
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ihdk_pkg::S_DONE;
                end
                else
                begin
                    heap_raddr = parent;
                    p_next     = parent;
                    state_next = ihdk_pkg::S_UP_CMP;
                end
            end

            // Parent moves down into the hole when the moving entry is lighter.
            ihdk_pkg::S_UP_CMP:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (ent_reg.w < heap_rdata.w)
                begin
                    heap_wdata = heap_rdata;
                    slot_waddr = heap_rdata.dst;
                    k_next     = p_reg;
                    state_next = ihdk_pkg::S_UP;
                end
                else
                begin
                    state_next = ihdk_pkg::S_DONE;
                end
            end

            // Sift down: read the left child if there is one.
            ihdk_pkg::S_DOWN:
            begin
                if (l_idx < cnt_idx)
                begin
                    heap_raddr = l_idx[SLOT_W-1:0];
                    state_next = ihdk_pkg::S_DOWN_L;
                end
                else
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ihdk_pkg::S_DONE;
                end
            end

            // Left child seen; read the right child or settle this level.
            ihdk_pkg::S_DOWN_L:
            begin
                sel_next  = heap_rdata.w < ent_reg.w;
                cand_next = (heap_rdata.w < ent_reg.w) ? heap_rdata : ent_reg;
                if (r_idx < cnt_idx)
                begin
                    heap_raddr = r_idx[SLOT_W-1:0];
                    state_next = ihdk_pkg::S_DOWN_R;
                end
                else
                begin
                    heap_we = 1'b1;
                    slot_we = 1'b1;
                    if (heap_rdata.w < ent_reg.w)
                    begin
                        heap_wdata = heap_rdata;
                        slot_waddr = heap_rdata.dst;
                        k_next     = l_idx[SLOT_W-1:0];
                        state_next = ihdk_pkg::S_DOWN;
                    end
                    else
                    begin
                        state_next = ihdk_pkg::S_DONE;
                    end
                end
            end

            // Right child wins only when strictly lighter than the best so far.
            ihdk_pkg::S_DOWN_R:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (heap_rdata.w < cand_reg.w)
                begin
                    heap_wdata = heap_rdata;
                    slot_waddr = heap_rdata.dst;
                    k_next     = r_idx[SLOT_W-1:0];
                    state_next = ihdk_pkg::S_DOWN;
                end
                else if (sel_reg)
                begin
                    heap_wdata = cand_reg;
                    slot_waddr = cand_reg.dst;
                    k_next     = l_idx[SLOT_W-1:0];
                    state_next = ihdk_pkg::S_DOWN;
                end
                else
                begin
                    state_next = ihdk_pkg::S_DONE;
                end
            end

            // Hand the result to the output register once it is free.
            ihdk_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next.status     = status_reg;
                    out_next.out_vertex = res_reg.dst;
                    out_next.out_source = res_reg.src;
                    out_next.out_weight = ow_wide[31:0];
                    out_next.count      = cnt_wide[8:0];
                    out_next.empty_res  = (count_reg == '0);
                    out_valid_next      = 1'b1;
                    state_next          = ihdk_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ihdk_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    // An accepted item makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    // Every heap write is paired with a slot map update for the entry written.
    assert property (@(posedge clk) disable iff (!rst_n)
        heap_we |-> slot_we && (slot_waddr == heap_wdata.dst) && (slot_wdata == heap_waddr))
        else $error("heap write without matching slot update");

    // The entry count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        17'(count_reg) <= 17'(CAPACITY))
        else $error("entry count beyond capacity");
`endif

endmodule

>>> bench/tb.sv
// Testbench for the indexed min-heap with decrease-key: random and directed items against a built-in model.
`timescale 1ns / 100ps

module tb;

    localparam int HEAP_CAP = 256;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    ihdk_pkg::req_item_t req;
    logic rsp_valid;
    logic rsp_ready;
    ihdk_pkg::rsp_item_t rsp;

    indexed_min_heap_decrease_key dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    // Model state of the heap.
    logic [7:0]  hp_dst [HEAP_CAP];
    logic [7:0]  hp_src [HEAP_CAP];
    logic [31:0] hp_w   [HEAP_CAP];
    int unsigned slot_of [256];
    bit          present [256];
    int unsigned n_entries;

    ihdk_pkg::req_item_t pending_items[$];
    ihdk_pkg::rsp_item_t expected_rsps[$];
    int  errors;
    int  sent;
    bit  send_idle_en;
    bit  recv_idle_en;
    bit  hold_recv;
    bit  hold_send;
    bit  req_ready_seen;
    int  send_gap;
    int  recv_gap;

    // Swap two heap slots and fix their map entries.
    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic [7:0]  td;
        logic [7:0]  ts;
        logic [31:0] tw;
        td = hp_dst[a]; ts = hp_src[a]; tw = hp_w[a];
        hp_dst[a] = hp_dst[b]; hp_src[a] = hp_src[b]; hp_w[a] = hp_w[b];
        hp_dst[b] = td; hp_src[b] = ts; hp_w[b] = tw;
        slot_of[hp_dst[a]] = a;
        slot_of[hp_dst[b]] = b;
    endfunction

    function automatic void sift_up(input int unsigned k);
        int unsigned p;
        while (k > 0)
        begin
            p = (k - 1) / 2;
            if (hp_w[k] >= hp_w[p]) break;
            swap_slots(k, p);
            k = p;
        end
    endfunction

    function automatic void sift_down(input int unsigned k);
        int unsigned best;
        int unsigned l;
        int unsigned r;
        forever
        begin
            best = k;
            l = 2 * k + 1;
            r = 2 * k + 2;
            if (l < n_entries && hp_w[l] < hp_w[best]) best = l;
            if (r < n_entries && hp_w[r] < hp_w[best]) best = r;
            if (best == k) break;
            swap_slots(k, best);
            k = best;
        end
    endfunction

    // Apply one item to the model and return the result it should give.
    function automatic ihdk_pkg::rsp_item_t heap_apply(input ihdk_pkg::req_item_t it);
        ihdk_pkg::rsp_item_t r;
        int unsigned k;
        r = '0;
        if (it.mode == ihdk_pkg::MODE_POP)
        begin
            if (n_entries == 0)
            begin
                r.status = ihdk_pkg::ST_UNDERFLOW;
            end
            else
            begin
                r.out_vertex = hp_dst[0];
                r.out_source = hp_src[0];
                r.out_weight = hp_w[0];
                present[hp_dst[0]] = 1'b0;
                n_entries--;
                hp_dst[0] = hp_dst[n_entries];
                hp_src[0] = hp_src[n_entries];
                hp_w[0] = hp_w[n_entries];
                if (n_entries > 0)
                begin
                    slot_of[hp_dst[0]] = 0;
                    sift_down(0);
                end
                r.status = ihdk_pkg::ST_POPPED;
            end
        end
        else if (int'(it.vertex) >= HEAP_CAP)
        begin
            r.status = ihdk_pkg::ST_BAD_VERT;
        end
        else if (present[it.vertex])
        begin
            k = slot_of[it.vertex];
            if (k < n_entries && it.weight < hp_w[k])
            begin
                hp_w[k] = it.weight;
                hp_src[k] = it.source;
                sift_up(k);
                r.status = ihdk_pkg::ST_DECREASED;
            end
            else
            begin
                r.status = ihdk_pkg::ST_IGNORED;
            end
        end
        else if (n_entries >= HEAP_CAP)
        begin
            r.status = ihdk_pkg::ST_OVERFLOW;
        end
        else
        begin
            k = n_entries;
            hp_dst[k] = it.vertex;
            hp_src[k] = it.source;
            hp_w[k] = it.weight;
            slot_of[it.vertex] = k;
            present[it.vertex] = 1'b1;
            n_entries++;
            sift_up(k);
            r.status = ihdk_pkg::ST_INSERTED;
        end
        r.count = n_entries[8:0];
        r.empty_res = (n_entries == 0);
        return r;
    endfunction

    function automatic ihdk_pkg::req_item_t make_push(input logic [7:0] v,
                                                      input logic [7:0] s,
                                                      input logic [31:0] w);
        ihdk_pkg::req_item_t it;
        it.mode = ihdk_pkg::MODE_PUSH;
        it.vertex = v;
        it.source = s;
        it.weight = w;
        return it;
    endfunction

    function automatic ihdk_pkg::req_item_t make_pop();
        ihdk_pkg::req_item_t it;
        it.mode = ihdk_pkg::MODE_POP;
        it.vertex = 8'($urandom);
        it.source = 8'($urandom);
        it.weight = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Clock.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Sender: offers items from the queue at the falling edge.
    initial
    begin
        req_valid = 0;
        req = '0;
    end
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_ready_seen)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 0;
                end
                else if (pending_items.size() > 0 && !hold_send)
                begin
                    req <= pending_items.pop_front();
                    req_valid <= 1;
                    if (send_idle_en && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 13);
                end
                else
                begin
                    req_valid <= 0;
                end
            end
        end
    end

    // Capture of the request handshake at the rising edge.
    always @(posedge clk)
    begin
        req_ready_seen <= rst_n && req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
        begin
            expected_rsps.push_back(heap_apply(req));
            sent <= sent + 1;
        end
    end

    // Receiver: ready changes at the falling edge.
    initial rsp_ready = 0;
    always @(negedge clk)
    begin
        if (!rst_n || hold_recv)
        begin
            rsp_ready <= 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 0;
        end
        else if (recv_idle_en && $urandom_range(0, 7) == 0)
        begin
            recv_gap <= $urandom_range(1, 13) - 1;
            rsp_ready <= 0;
        end
        else
        begin
            rsp_ready <= 1;
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        ihdk_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report("unexpected result", 64'(rsp), 64'(0));
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                    report("status", 64'(rsp.status), 64'(want.status));
                if (rsp.out_vertex !== want.out_vertex)
                    report("out_vertex", 64'(rsp.out_vertex), 64'(want.out_vertex));
                if (rsp.out_source !== want.out_source)
                    report("out_source", 64'(rsp.out_source), 64'(want.out_source));
                if (rsp.out_weight !== want.out_weight)
                    report("out_weight", 64'(rsp.out_weight), 64'(want.out_weight));
                if (rsp.count !== want.count)
                    report("count", 64'(rsp.count), 64'(want.count));
                if (rsp.empty_res !== want.empty_res)
                    report("empty_res", 64'(rsp.empty_res), 64'(want.empty_res));
            end
        end
    end

    // Wait until the queue is drained and every item has been taken.
    task automatic wait_sent(input int total);
        while (sent < total) @(posedge clk);
    endtask

    task automatic wait_results();
        while (expected_rsps.size() > 0) @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        int total;
        int v;
        errors = 0;
        sent = 0;
        send_gap = 0;
        recv_gap = 0;
        send_idle_en = 0;
        recv_idle_en = 0;
        hold_recv = 0;
        hold_send = 0;
        n_entries = 0;
        for (int i = 0; i < 256; i++)
        begin
            present[i] = 0;
            slot_of[i] = 0;
        end
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: underflow, extremes, ties, decrease, ignore, pops.
        pending_items.push_back(make_pop());
        pending_items.push_back(make_push(8'd0, 8'd255, 32'hFFFF_FFFF));
        pending_items.push_back(make_push(8'd255, 8'd0, 32'd0));
        pending_items.push_back(make_push(8'd170, 8'h55, 32'd7));
        pending_items.push_back(make_push(8'd85, 8'hAA, 32'd7));
        pending_items.push_back(make_push(8'd1, 8'd1, 32'd7));
        pending_items.push_back(make_push(8'd0, 8'd9, 32'hFFFF_FFFF));
        pending_items.push_back(make_push(8'd0, 8'd9, 32'h8000_0000));
        pending_items.push_back(make_push(8'd85, 8'd3, 32'd7));
        pending_items.push_back(make_push(8'd1, 8'd4, 32'd8));
        pending_items.push_back(make_push(8'd1, 8'd5, 32'd0));
        pending_items.push_back(make_push(8'd255, 8'd6, 32'd0));
        for (int i = 0; i < 7; i++) pending_items.push_back(make_pop());
        total = pending_items.size();
        wait_sent(total);
        wait_results();

        // Fill to capacity, then ignored and decreasing pushes; receiver held off.
        send_idle_en = 1;
        recv_idle_en = 1;
        hold_recv = 1;
        for (int i = 0; i < 256; i++)
            pending_items.push_back(make_push(i[7:0], 8'($urandom), rand_weight()));
        total += 256;
        repeat (200) @(posedge clk);
        hold_recv = 0;
        pending_items.push_back(make_push(8'd17, 8'($urandom), 32'hFFFF_FFFF));
        pending_items.push_back(make_push(8'd17, 8'($urandom), $urandom_range(0, 3)));
        total += 2;
        for (int i = 0; i < 60; i++) pending_items.push_back(make_pop());
        total += 60;
        // Pause the sender until every result is back.
        wait_sent(total);
        hold_send = 1;
        wait_results();
        hold_send = 0;

        // Random mix of pushes, decreases and pops.
        for (int i = 0; i < 100; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pending_items.push_back(make_pop());
            end
            else
            begin
                v = $urandom_range(0, 255);
                pending_items.push_back(make_push(v[7:0], 8'($urandom), rand_weight()));
            end
        end
        total += 100;
        wait_sent(total);

        // Last part: no idling, mostly pops.
        send_idle_en = 0;
        recv_idle_en = 0;
        for (int i = 0; i < 40; i++)
        begin
            v = $urandom_range(0, 255);
            pending_items.push_back(make_push(v[7:0], 8'($urandom), $urandom));
        end
        for (int i = 0; i < 170; i++) pending_items.push_back(make_pop());
        total += 210;
        wait_sent(total);
        wait_results();
        repeat (60) @(posedge clk);

        if (errors == 0)
            $display("indexed_min_heap_decrease_key: match");
        else
            $display("indexed_min_heap_decrease_key: mismatch");
        $finish;
    end

    // Timeout.
    initial
    begin
        #20ms;
        $display("indexed_min_heap_decrease_key: mismatch");
        $finish;
    end
endmodule

>>> sim.f
rtl/ihdk_pkg.sv
rtl/ihdk_heap_ram.sv
rtl/ihdk_slot_map.sv
rtl/indexed_min_heap_decrease_key.sv
bench/tb.sv
